// ===== rtl/hdlf_pkg.sv =====
// shared types, constants and character helpers for the hex dump line formatter
// used by hdlf_ctrl, hdlf_datapath and hex_dump_line_formatter; no dependencies
package hdlf_pkg;

   // line geometry
   localparam int BYTES_PER_LINE_DEF = 16;
   localparam int STORE_DEPTH        = 16;
   localparam int STORE_IDX_W        = 4;
   localparam int FILL_W             = 5;
   localparam int CNT_W              = 6;

   // ascii codes
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_BAR     = 8'h7c;
   localparam logic [7:0] CHAR_NL      = 8'h0a;
   localparam logic [7:0] CHAR_DOT     = 8'h2e;
   localparam logic [7:0] PRINT_LOW    = 8'h20;
   localparam logic [7:0] PRINT_HIGH   = 8'h7e;
   localparam logic [3:0] NIBBLE_MASK  = 4'hf;

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_LEAD,
      S_HI,
      S_LO,
      S_PAD,
      S_SEP,
      S_OPEN,
      S_GUT,
      S_CLOSE,
      S_NL
   } state_type;

   // character source for the output register
   typedef enum logic [2:0] {
      SEL_SPACE,
      SEL_HI,
      SEL_LO,
      SEL_BAR,
      SEL_GUT,
      SEL_NL
   } char_sel_type;

   // counter operation
   typedef enum logic [2:0] {
      CNT_HOLD,
      CNT_DEC,
      CNT_INC,
      CNT_LOAD_PAD,
      CNT_LOAD_ONE,
      CNT_ZERO
   } cnt_op_type;

   typedef struct packed {
      logic         accept;
      logic         emit;
      char_sel_type sel;
      logic         last;
      cnt_op_type   cnt_op;
      logic         clear_fill;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic cnt_zero;
      logic close;
      logic pad_zero;
      logic gut_last;
   } status_type;

   // lowercase hex digit of a nibble
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) c = 8'h30 + {4'd0, nib};
      else             c = 8'h57 + {4'd0, nib};
      return c;
   endfunction

   // printable bytes pass, all others show as a dot
   function automatic logic [7:0] gutter_char(input logic [7:0] b);
      logic [7:0] c;
      if (b >= PRINT_LOW && b <= PRINT_HIGH) c = b;
      else                                   c = CHAR_DOT;
      return c;
   endfunction

endpackage

// ===== rtl/hex_dump_line_formatter.sv =====
// a byte taken in S_IDLE sends the sequencer to S_LEAD, which emits its first character
// throughput: one character per cycle while the output register is free; a byte
// emits lead spaces and its hex pair, plus padding, separator, bars, gutter and newline
// when it closes a line; the sequencer emits every character through a single output register
// reset: synchronous, active high; clears the sequencer, fill count, counter and valid
module hex_dump_line_formatter
   import hdlf_pkg::*;
#(
   parameter int BYTES_PER_LINE = BYTES_PER_LINE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_run_end
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   hdlf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // store, counters and output register
   hdlf_datapath #(
      .BYTES_PER_LINE (BYTES_PER_LINE)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_char   (rsp_out_char),
      .rsp_run_end    (rsp_run_end),
      .cmd            (cmd),
      .status         (status)
   );

endmodule

// ===== rtl/hdlf_ctrl.sv =====
// sequencer for the hex dump line formatter: walks the characters of one byte
// depends on hdlf_pkg; drives the datapath through cmd_type, reads status_type
module hdlf_ctrl
   import hdlf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      step;

   // a character may be produced when the output register is free
   assign step      = status.out_free;
   assign req_ready = (state_ff == S_IDLE);

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_LEAD;
         S_LEAD:  if (step && status.cnt_zero) state_in = S_HI;
         S_HI:    if (step) state_in = S_LO;
         S_LO: begin
            if (step) begin
               if (!status.close)        state_in = S_IDLE;
               else if (status.pad_zero) state_in = S_SEP;
               else                      state_in = S_PAD;
            end
         end
         S_PAD:   if (step && status.cnt_zero) state_in = S_SEP;
         S_SEP:   if (step && status.cnt_zero) state_in = S_OPEN;
         S_OPEN:  if (step) state_in = S_GUT;
         S_GUT:   if (step && status.gut_last) state_in = S_CLOSE;
         S_CLOSE: if (step) state_in = S_NL;
         S_NL:    if (step) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd            = '0;
      cmd.sel        = SEL_SPACE;
      cmd.cnt_op     = CNT_HOLD;
      unique case (state_ff)
         S_IDLE: cmd.accept = req_valid;
         S_LEAD: begin
            cmd.emit = step;
            if (!status.cnt_zero) cmd.cnt_op = CNT_DEC;
         end
         S_HI: begin
            cmd.emit = step;
            cmd.sel  = SEL_HI;
         end
         S_LO: begin
            cmd.emit = step;
            cmd.sel  = SEL_LO;
            cmd.last = !status.close;
            if (status.pad_zero) cmd.cnt_op = CNT_LOAD_ONE;
            else                 cmd.cnt_op = CNT_LOAD_PAD;
         end
         S_PAD: begin
            cmd.emit = step;
            if (status.cnt_zero) cmd.cnt_op = CNT_LOAD_ONE;
            else                 cmd.cnt_op = CNT_DEC;
         end
         S_SEP: begin
            cmd.emit = step;
            if (!status.cnt_zero) cmd.cnt_op = CNT_DEC;
         end
         S_OPEN: begin
            cmd.emit   = step;
            cmd.sel    = SEL_BAR;
            cmd.cnt_op = CNT_ZERO;
         end
         S_GUT: begin
            cmd.emit   = step;
            cmd.sel    = SEL_GUT;
            cmd.cnt_op = CNT_INC;
         end
         S_CLOSE: begin
            cmd.emit = step;
            cmd.sel  = SEL_BAR;
         end
         S_NL: begin
            cmd.emit       = step;
            cmd.sel        = SEL_NL;
            cmd.last       = 1'b1;
            cmd.clear_fill = step;
         end
         default: cmd = '0;
      endcase
   end

endmodule

// ===== rtl/hdlf_datapath.sv =====
// datapath of the hex dump line formatter: line store, counters, output register
// depends on hdlf_pkg; controlled by hdlf_ctrl through cmd_type
module hdlf_datapath
   import hdlf_pkg::*;
#(
   parameter int BYTES_PER_LINE = BYTES_PER_LINE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_run_end,
   input  cmd_type    cmd,
   output status_type status
);

   localparam logic [FILL_W-1:0] LINE_LEN = FILL_W'(BYTES_PER_LINE);

   logic [7:0]        store [STORE_DEPTH];
   logic [7:0]        byte_ff;
   logic              fin_ff;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic [FILL_W-1:0] room;
   logic [CNT_W-1:0]  pad;
   logic [FILL_W-1:0] fill_dec;
   logic [7:0]        gut_ff;
   logic              valid_ff;
   logic              valid_in;
   logic [7:0]        char_ff;
   logic [7:0]        char_in;
   logic              end_ff;

   // pad length of the hex column, three characters per missing byte
   assign room     = LINE_LEN - fill_ff;
   assign pad      = {room, 1'b0} + {1'b0, room};
   assign fill_dec = fill_ff - FILL_W'(1);

   assign status.out_free = !valid_ff || rsp_ready;
   assign status.cnt_zero = (cnt_ff == '0);
   assign status.close    = (fill_ff >= LINE_LEN) || fin_ff;
   assign status.pad_zero = (fill_ff == LINE_LEN);
   assign status.gut_last = (cnt_ff[STORE_IDX_W-1:0] == fill_dec[STORE_IDX_W-1:0]);

   // line store, written at the open slot on each accepted byte
   always_ff @(posedge clock) begin
      if (cmd.accept) store[fill_ff[STORE_IDX_W-1:0]] <= req_data_byte;
   end

   // gutter byte, registered read at the next gutter index
   always_ff @(posedge clock) begin
      gut_ff <= store[cnt_in[STORE_IDX_W-1:0]];
   end

   // current byte
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         byte_ff <= req_data_byte;
         fin_ff  <= req_final_byte;
      end
   end

   // line fill count
   always_comb begin
      fill_in = fill_ff;
      if (cmd.accept)          fill_in = fill_ff + FILL_W'(1);
      else if (cmd.clear_fill) fill_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) fill_ff <= '0;
      else       fill_ff <= fill_in;
   end

   // shared counter: lead spaces, padding, separator, gutter index
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.accept) begin
         cnt_in = (fill_ff == '0) ? CNT_W'(1) : '0;
      end else if (cmd.emit) begin
         unique case (cmd.cnt_op)
            CNT_HOLD:     cnt_in = cnt_ff;
            CNT_DEC:      cnt_in = cnt_ff - CNT_W'(1);
            CNT_INC:      cnt_in = cnt_ff + CNT_W'(1);
            CNT_LOAD_PAD: cnt_in = pad - CNT_W'(1);
            CNT_LOAD_ONE: cnt_in = CNT_W'(1);
            CNT_ZERO:     cnt_in = '0;
            default:      cnt_in = cnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else       cnt_ff <= cnt_in;
   end

   // character select
   always_comb begin
      unique case (cmd.sel)
         SEL_SPACE: char_in = CHAR_SPACE;
         SEL_HI:    char_in = hex_char(byte_ff[7:4] & NIBBLE_MASK);
         SEL_LO:    char_in = hex_char(byte_ff[3:0] & NIBBLE_MASK);
         SEL_BAR:   char_in = CHAR_BAR;
         SEL_GUT:   char_in = gutter_char(gut_ff);
         SEL_NL:    char_in = CHAR_NL;
         default:   char_in = CHAR_SPACE;
      endcase
   end

   // output register, holds one character until its transfer
   assign valid_in = cmd.emit ? 1'b1 : (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         char_ff <= char_in;
         end_ff  <= cmd.last;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_char = char_ff;
   assign rsp_run_end  = end_ff;

endmodule

// ===== rtl/hdlf_checker.sv =====
// port-level checks for the hex dump line formatter, bound to the top level
// depends on hdlf_pkg for character codes
module hdlf_checker
   import hdlf_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_char,
   input logic       rsp_run_end
);

   // a stalled result holds its character
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char))
      else $error("stalled result changed");

   // a new byte is never taken in the cycle after a transfer in
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted twice in a row");

   // while a non-final character waits, no new byte is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_end |-> !req_ready)
      else $error("input ready while a run is open");

   // a newline always ends its run
   a_nl_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_char == CHAR_NL |-> rsp_run_end)
      else $error("newline without run end");

endmodule

bind hex_dump_line_formatter hdlf_checker u_hdlf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_char (rsp_out_char),
   .rsp_run_end  (rsp_run_end)
);

// ===== tb/tb_top.sv =====
// self-checking testbench for hex_dump_line_formatter: drives payload bytes, predicts the
// dump characters in a scoreboard class and checks every character transfer
// depends on rtl/hdlf_pkg.sv and rtl/hex_dump_line_formatter.sv
`timescale 1ns / 1ps

module tb_top;
   import hdlf_pkg::*;

   localparam int BPL          = BYTES_PER_LINE_DEF;
   localparam int DRAIN_CYCLES = 20;
   localparam int IDLE_LIMIT   = 3000;
   localparam int BYTE_TARGET  = 380;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AT      = 100;
   localparam int PAUSE_AT     = 220;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_data_byte;
   logic       req_final_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_char;
   logic       rsp_run_end;

   // predicted dump text and line state
   class dump_scoreboard;
      typedef struct {
         logic [7:0] ch;
         logic       last;
      } dump_char_type;

      dump_char_type pending_chars[$];
      logic [7:0]    line_bytes[BPL];
      int unsigned   line_fill;
      int            mismatches;
      string         digits = "0123456789abcdef";

      function void push_char(logic [7:0] c);
         dump_char_type item;
         item.ch   = c;
         item.last = 1'b0;
         pending_chars.insert(pending_chars.size(), item);
      endfunction

      // one accepted byte: hex pair, and the whole line tail when the line closes
      function void note_byte(logic [7:0] b, logic fin);
         int unsigned pad;
         logic [7:0]  g;
         if (line_fill == 0) begin
            push_char(CHAR_SPACE);
            push_char(CHAR_SPACE);
         end else begin
            push_char(CHAR_SPACE);
         end
         push_char(digits[b[7:4]]);
         push_char(digits[b[3:0]]);
         line_bytes[line_fill] = b;
         line_fill++;
         if (line_fill >= BPL || fin) begin
            pad = 3 * (BPL - line_fill);
            repeat (pad) push_char(CHAR_SPACE);
            push_char(CHAR_SPACE);
            push_char(CHAR_SPACE);
            push_char(CHAR_BAR);
            for (int i = 0; i < line_fill; i++) begin
               g = line_bytes[i];
               push_char((g >= PRINT_LOW && g <= PRINT_HIGH) ? g : CHAR_DOT);
            end
            push_char(CHAR_BAR);
            push_char(CHAR_NL);
            line_fill = 0;
         end
         pending_chars[pending_chars.size() - 1].last = 1'b1;
      endfunction

      // one character transfer against the oldest prediction
      function void check_char(logic [7:0] c, logic e);
         dump_char_type want;
         if (pending_chars.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected char: got %h run_end %b", c, e);
            return;
         end
         want = pending_chars.pop_front();
         if (want.ch !== c || want.last !== e) begin
            mismatches++;
            if (mismatches <= 10)
               $display("char mismatch: expected %h run_end %b, got %h run_end %b",
                        want.ch, want.last, c, e);
         end
      endfunction

      function void check_leftover();
         if (pending_chars.size() != 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0d predicted chars never arrived", pending_chars.size());
         end
      endfunction
   endclass

   dump_scoreboard sb = new();
   int bytes_sent;
   int idle_cycles;
   bit held_off;

   hex_dump_line_formatter #(.BYTES_PER_LINE(BPL)) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_char   (rsp_out_char),
      .rsp_run_end    (rsp_run_end)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // biased byte values: gutter boundaries, printable text, anything
   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) begin
         case ($urandom_range(0, 6))
            0: return 8'h00;
            1: return 8'h1f;
            2: return 8'h20;
            3: return 8'h7e;
            4: return 8'h7f;
            5: return 8'h80;
            default: return 8'hff;
         endcase
      end
      if (r < 50) return 8'($urandom_range(8'h20, 8'h7e));
      return 8'($urandom_range(0, 255));
   endfunction

   // one input transfer, with an optional idle gap first
   task automatic send_byte(input logic [7:0] b, input logic fin, input bit tight);
      int gap;
      gap = tight ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= b;
      req_final_byte <= fin;
      do @(posedge clock); while (!(req_valid && req_ready));
      bytes_sent++;
   endtask

   task automatic send_datagram(input int len, input bit tight);
      for (int i = 0; i < len; i++)
         send_byte(pick_byte(), (i == len - 1), tight);
   endtask

   // sender stops until every predicted char has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // stimulus
   initial begin
      int r;
      int len;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_data_byte  <= 8'h00;
      req_final_byte <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single-byte datagram, then short ones across the gutter boundaries
      send_byte(8'h00, 1'b1, 1'b0);
      send_byte(8'hff, 1'b0, 1'b0);
      send_byte(8'h20, 1'b1, 1'b0);
      send_byte(8'h1f, 1'b0, 1'b0);
      send_byte(8'h7f, 1'b0, 1'b0);
      send_byte(8'h7e, 1'b1, 1'b0);
      // full line without a final mark, every nibble value, then a new line
      for (int i = 0; i < BPL; i++)
         send_byte(8'(i * 17), 1'b0, 1'b0);
      send_byte(8'h80, 1'b1, 1'b0);
      // full line that is also the datagram end
      for (int i = 0; i < BPL; i++)
         send_byte(8'(8'h41 + i), (i == BPL - 1), 1'b1);

      // random datagrams
      while (bytes_sent < BYTE_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 15)      len = 1;
         else if (r < 30) len = BPL;
         else if (r < 38) len = 2 * BPL;
         else if (r < 45) len = BPL + 1;
         else             len = $urandom_range(2, 40);
         send_datagram(len, ($urandom_range(0, 9) < 2));
         if (bytes_sent >= PAUSE_AT && bytes_sent < PAUSE_AT + 2 * BPL + 40)
            wait_drained();
      end

      // end of run
      wait_drained();
      sb.check_leftover();
      if (sb.mismatches == 0) begin
         $display("** hex_dump_line_formatter: PASSED **");
      end else begin
         $display("** hex_dump_line_formatter: FAILED **");
      end
      $finish;
   end

   // receiver: random ready, long free-running stretches, one long hold-off
   initial begin
      int gap;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && bytes_sent >= HOLD_AT) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 9) == 0) repeat (150) @(posedge clock);
         else                           repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   end

   // input transfer monitor feeds the prediction
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         sb.note_byte(req_data_byte, req_final_byte);
   end

   // output transfer monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_char(rsp_out_char, rsp_run_end);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", idle_cycles);
         $display("** hex_dump_line_formatter: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
